// ----- rtl/core/otb_pkg.sv -----
package otb_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    RES_EXPIRED = 3'd0,
    RES_STARTED = 3'd1,
    RES_BUSY    = 3'd2,
    RES_STOPPED = 3'd3,
    RES_IGNORED = 3'd4
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_TIMING = 2'd1,
    ST_FIRED  = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DONE
  } fsm_t;

endpackage

// ----- rtl/core/one_shot_timer_bank.sv -----
// Start, stop ignored, unused kind: decoded, then the result is registered.
// Stop of a timing slot and tick: list scan of one entry per cycle while no
// expiry waits on a stalled output; expiries stream out one per cycle while
// the output is ready. One item at a time, accepted only in the idle state;
// the single elapsed-time subtract/compare unit walks the arming-order list.
// Reset (rst_n low, synchronous): time zero, all slots idle, list empty.
module one_shot_timer_bank import otb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot[3:0], duration[35:4], zero[39:36]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // slot_out[3:0], zero[7:4]
  output logic [3:0]  out_tuser,  // event_res[2:0], none_expired[3]
  output logic        out_tlast
);

  fsm_t                state_r, state_nxt;
  logic [1:0]          kind_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [TIME_W-1:0]   dur_r;
  logic [TIME_W-1:0]   now_r;
  slot_st_t            status_r [SLOTS];
  logic [TIME_W-1:0]   stamp_r  [SLOTS];
  logic [TIME_W-1:0]   len_r    [SLOTS];
  logic [SLOT_W-1:0]   order_r  [SLOTS];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    rd_r;
  logic [CNT_W-1:0]    wr_r;
  logic                pend_v_r;
  logic [SLOT_W-1:0]   pend_slot_r;
  logic                out_valid_r;
  res_t                out_res_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_none_r;
  logic                out_last_r;

  logic                in_fire;
  logic                out_free;
  logic [SLOT_W-1:0]   cur_s;
  logic [TIME_W-1:0]   elapsed;
  logic                hit;
  logic                scan_end;
  logic                stall;
  logic                start_ok;

  logic                emit;
  res_t                emit_res;
  logic [SLOT_W-1:0]   emit_slot;
  logic                emit_none;
  logic                emit_last;
  logic                arm_we;
  logic                stat_we;
  logic [SLOT_W-1:0]   stat_idx;
  slot_st_t            stat_val;
  logic                ord_we;
  logic                count_we;
  logic                now_inc;
  logic                rd_inc;
  logic                wr_inc;
  logic                pend_set;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_slot_r};
  assign out_tuser  = {out_none_r, out_res_r};
  assign out_tlast  = out_last_r;

  assign cur_s    = order_r[rd_r[SLOT_W-1:0]];
  assign elapsed  = now_r - stamp_r[cur_s];
  assign hit      = (kind_r == KIND_STOP) ? (cur_s == slot_r) : (elapsed >= len_r[cur_s]);
  assign scan_end = (rd_r == count_r);
  assign stall    = (kind_r == KIND_TICK) && hit && pend_v_r && !out_free;
  assign start_ok = (status_r[slot_r] != ST_TIMING) && (count_r < CNT_W'(SLOTS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (kind_r)
          KIND_TICK: state_nxt = S_SCAN;
          KIND_STOP: begin
            if (status_r[slot_r] == ST_TIMING) state_nxt = S_SCAN;
            else if (out_free) state_nxt = S_IDLE;
          end
          default: begin
            if (out_free) state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_res  = RES_EXPIRED;
    emit_slot = slot_r;
    emit_none = 1'b0;
    emit_last = 1'b1;
    arm_we    = 1'b0;
    stat_we   = 1'b0;
    stat_idx  = slot_r;
    stat_val  = ST_IDLE;
    ord_we    = 1'b0;
    count_we  = 1'b0;
    now_inc   = 1'b0;
    rd_inc    = 1'b0;
    wr_inc    = 1'b0;
    pend_set  = 1'b0;
    case (state_r)
      S_DECODE: begin
        case (kind_r)
          KIND_START: begin
            if (out_free) begin
              emit = 1'b1;
              if (start_ok) begin
                emit_res = RES_STARTED;
                arm_we   = 1'b1;
                stat_we  = 1'b1;
                stat_val = ST_TIMING;
              end else begin
                emit_res = RES_BUSY;
              end
            end
          end
          KIND_STOP: begin
            if (status_r[slot_r] == ST_TIMING) begin
              stat_we  = 1'b1;
              stat_val = ST_IDLE;
            end else if (out_free) begin
              emit     = 1'b1;
              emit_res = RES_IGNORED;
            end
          end
          KIND_TICK: now_inc = 1'b1;
          default: begin
            if (out_free) begin
              emit     = 1'b1;
              emit_res = RES_IGNORED;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (!scan_end && !stall) begin
          rd_inc = 1'b1;
          if (hit) begin
            if (kind_r == KIND_TICK) begin
              stat_we   = 1'b1;
              stat_idx  = cur_s;
              stat_val  = ST_FIRED;
              pend_set  = 1'b1;
              emit      = pend_v_r;
              emit_res  = RES_EXPIRED;
              emit_slot = pend_slot_r;
              emit_last = 1'b0;
            end
          end else begin
            ord_we = 1'b1;
            wr_inc = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          count_we = 1'b1;
          if (kind_r == KIND_STOP) begin
            emit_res = RES_STOPPED;
          end else begin
            emit_res  = RES_EXPIRED;
            emit_slot = pend_v_r ? pend_slot_r : '0;
            emit_none = !pend_v_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) status_r[i] <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        rd_r     <= '0;
        wr_r     <= '0;
        pend_v_r <= 1'b0;
      end else begin
        if (rd_inc) rd_r <= rd_r + 1'b1;
        if (wr_inc) wr_r <= wr_r + 1'b1;
        if (pend_set) pend_v_r <= 1'b1;
      end
      if (now_inc) now_r <= now_r + 1'b1;
      if (arm_we) count_r <= count_r + 1'b1;
      else if (count_we) count_r <= wr_r;
      if (stat_we) status_r[stat_idx] <= stat_val;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      slot_r <= in_tdata[3:0];
      dur_r  <= in_tdata[35:4];
    end
    if (arm_we) begin
      stamp_r[slot_r]                 <= now_r;
      len_r[slot_r]                   <= dur_r;
      order_r[count_r[SLOT_W-1:0]]    <= slot_r;
    end
    if (ord_we) order_r[wr_r[SLOT_W-1:0]] <= cur_s;
    if (pend_set) pend_slot_r <= cur_s;
    if (emit) begin
      out_res_r  <= emit_res;
      out_slot_r <= emit_slot;
      out_none_r <= emit_none;
      out_last_r <= emit_last;
    end
  end

endmodule

// ----- rtl/core/otb_checker.sv -----
module otb_checker import otb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |->
      out_tlast && out_tuser[2:0] == RES_EXPIRED && out_tdata[3:0] == 4'd0)
    else $error("bad no-expiry result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != RES_EXPIRED |-> out_tlast && !out_tuser[3])
    else $error("non-expiry result not final");

  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

endmodule

bind one_shot_timer_bank otb_checker u_otb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- bench/one_shot_timer_bank_chk.sv -----
`timescale 1ns / 1ps
module one_shot_timer_bank_chk import otb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // slot[3:0], duration[35:4], zero[39:36]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // slot_out[3:0], zero[7:4]
  input  logic [3:0]  out_tuser,  // event_res[2:0], none_expired[3]
  input  logic        out_tlast,
  output int          fails,
  output int          pending
);

  typedef struct {
    res_t        res;
    logic [3:0]  slot;
    logic        none;
    logic        last;
  } timer_event_t;

  timer_event_t        due_events[$];
  logic [TIME_W-1:0]   now_ticks;
  slot_st_t            slot_state [SLOTS];
  logic [TIME_W-1:0]   armed_at [SLOTS];
  logic [TIME_W-1:0]   run_len [SLOTS];
  logic [SLOT_W-1:0]   arm_list[$];

  function automatic void post_event(res_t res, logic [3:0] slot, logic none, logic last);
    timer_event_t ev;
    ev.res  = res;
    ev.slot = slot;
    ev.none = none;
    ev.last = last;
    due_events.push_back(ev);
  endfunction

  task automatic advance_timers(logic [1:0] kind, logic [3:0] slot, logic [31:0] dur);
    logic [SLOT_W-1:0] keep[$];
    logic [SLOT_W-1:0] s;
    int fired;
    fired = 0;
    case (kind)
      KIND_START: begin
        if (slot_state[slot] == ST_TIMING || arm_list.size() >= SLOTS) begin
          post_event(RES_BUSY, slot, 1'b0, 1'b1);
        end else begin
          slot_state[slot] = ST_TIMING;
          armed_at[slot]   = now_ticks;
          run_len[slot]    = dur;
          arm_list.push_back(slot);
          post_event(RES_STARTED, slot, 1'b0, 1'b1);
        end
      end
      KIND_STOP: begin
        if (slot_state[slot] != ST_TIMING) begin
          post_event(RES_IGNORED, slot, 1'b0, 1'b1);
        end else begin
          slot_state[slot] = ST_IDLE;
          foreach (arm_list[i])
            if (arm_list[i] != slot) keep.push_back(arm_list[i]);
          arm_list = keep;
          post_event(RES_STOPPED, slot, 1'b0, 1'b1);
        end
      end
      KIND_TICK: begin
        now_ticks = now_ticks + 1;
        foreach (arm_list[i]) begin
          s = arm_list[i];
          if (fired < SLOTS && (now_ticks - armed_at[s]) >= run_len[s]) begin
            slot_state[s] = ST_FIRED;
            post_event(RES_EXPIRED, s, 1'b0, 1'b0);
            fired++;
          end else begin
            keep.push_back(s);
          end
        end
        arm_list = keep;
        if (fired == 0) post_event(RES_EXPIRED, 4'd0, 1'b1, 1'b1);
        else due_events[due_events.size()-1].last = 1'b1;
      end
      default: begin
        post_event(RES_IGNORED, slot, 1'b0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    timer_event_t ev;
    if (!rst_n) begin
      due_events.delete();
      arm_list.delete();
      now_ticks = '0;
      for (int i = 0; i < SLOTS; i++) slot_state[i] = ST_IDLE;
      fails = 0;
    end else begin
      if (in_tvalid && in_tready)
        advance_timers(in_tuser, in_tdata[3:0], in_tdata[35:4]);
      if (out_tvalid && out_tready) begin
        if (due_events.size() == 0) begin
          if (fails < 10)
            $display("unexpected item: res %0d slot %0d none %0b last %0b",
                     out_tuser[2:0], out_tdata[3:0], out_tuser[3], out_tlast);
          fails++;
        end else begin
          ev = due_events.pop_front();
          if (out_tuser[2:0] !== ev.res || out_tdata[3:0] !== ev.slot ||
              out_tuser[3] !== ev.none || out_tlast !== ev.last) begin
            if (fails < 10)
              $display("mismatch: exp res %0d slot %0d none %0b last %0b, got res %0d slot %0d none %0b last %0b",
                       ev.res, ev.slot, ev.none, ev.last,
                       out_tuser[2:0], out_tdata[3:0], out_tuser[3], out_tlast);
            fails++;
          end
        end
      end
    end
    pending = due_events.size();
  end

endmodule

// ----- bench/one_shot_timer_bank_tb.sv -----
`timescale 1ns / 1ps
module one_shot_timer_bank_tb;
  import otb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         HOLD_LEN    = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int tx_idle_pct = 20;
  int rx_idle_pct = 67;
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int fails;
  int pending;

  always #6 clk = ~clk;

  one_shot_timer_bank uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  one_shot_timer_bank_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fails      (fails),
    .pending    (pending)
  );

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_tready  <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_LEN;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(logic [1:0] kind, logic [3:0] slot, logic [31:0] dur);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, dur, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(6);
    if (r < 75) return $urandom_range(40);
    if (r < 85) return $urandom;
    if (r < 92) return 32'hFFFF_FFFF - $urandom_range(15);
    return 32'h8000_0000 | $urandom;
  endfunction

  task automatic loose_item();
    int r;
    logic [1:0] kind;
    r = $urandom_range(99);
    if (r < 40)      kind = KIND_START;
    else if (r < 58) kind = KIND_STOP;
    else if (r < 95) kind = KIND_TICK;
    else             kind = KIND_UNUSED;
    send_item(kind, SLOT_W'($urandom_range(15)), pick_duration());
  endtask

  // mostly arm-then-tick sequences so that slots actually expire
  task automatic random_run(int target);
    int sent;
    int k;
    int m;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(1, 8);
        m = $urandom_range(2, 6);
        repeat (k) send_item(KIND_START, SLOT_W'($urandom_range(15)), $urandom_range(4));
        repeat (m) begin
          if ($urandom_range(3) == 0)
            send_item(KIND_STOP, SLOT_W'($urandom_range(15)), $urandom);
          else
            send_item(KIND_TICK, SLOT_W'($urandom_range(15)), $urandom);
        end
        sent += k + m;
      end else begin
        loose_item();
        sent++;
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 67;
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_STOP, 4'd5, 32'd0);
    send_item(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF);
    send_item(KIND_START, 4'd0, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, 4'd15, 32'hFFFF_FFFF);
    send_item(KIND_START, 4'd15, 32'd0);
    send_item(KIND_START, 4'd3, 32'd2);
    send_item(KIND_START, 4'd7, 32'd1);
    send_item(KIND_START, 4'd1, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_STOP, 4'd15, 32'd0);
    send_item(KIND_STOP, 4'd15, 32'd0);
    send_item(KIND_STOP, 4'd0, 32'd0);
    send_item(KIND_START, 4'd0, 32'd1);
    send_item(KIND_TICK, 4'd15, 32'hFFFF_FFFF);
    // all sixteen slots fire on one tick
    for (int i = 0; i < SLOTS; i++) send_item(KIND_START, SLOT_W'(i), 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    random_run(38);
    drain();

    tx_idle_pct = 67;
    rx_idle_pct = 20;
    hold_reqs <= hold_reqs + 1;
    random_run(38);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(38);
    drain();

    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
